### rtl/core/owc_pkg.sv
package owc_pkg;

	// tick counter width
	localparam int CNT_W = 10;
	// widest timing register and the common compare width
	localparam int CFG_W = 10;
	localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_WINDOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_LOW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY     = 3'd6;

	// request codes
	localparam logic [1:0] REQ_TICK    = 2'd0;
	localparam logic [1:0] REQ_CONVERT = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_PRES  = 2'd1;
	localparam logic [1:0] ST_ALL_ONES = 2'd2;

	// bus command bytes
	localparam logic [7:0] ROM_SKIP     = 8'hCC;
	localparam logic [7:0] FN_CONVERT   = 8'h44;
	localparam logic [7:0] FN_READ_PAD  = 8'hBE;

	localparam logic [15:0] RAW_ALL_ONES = 16'hFFFF;
	localparam logic signed [15:0] TEMP_INVALID = 16'sh7FFF;

	// timing register set
	typedef struct packed {
		logic [9:0] reset_low;
		logic [9:0] pres_window;
		logic [9:0] reset_tail;
		logic [3:0] slot_low;
		logic [3:0] read_sample;
		logic [9:0] slot;
		logic [7:0] recovery;
	} owc_cfg_t;

	// one result beat
	typedef struct packed {
		logic              pull;
		logic              busy;
		logic              done;
		logic [1:0]        status;
		logic signed [15:0] temp;
	} owc_res_t;

endpackage

### rtl/core/owc_cmd_if.sv
interface owc_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic       dq_level;

	modport source (output valid, output req_type, output dq_level, input ready);
	modport sink (input valid, input req_type, input dq_level, output ready);
endinterface

### rtl/core/owc_res_if.sv
interface owc_res_if;
	logic               valid;
	logic               ready;
	logic               dq_pull_low;
	logic               busy_res;
	logic               done_res;
	logic [1:0]         status;
	logic signed [15:0] temp_tenths;

	modport source (output valid, output dq_pull_low, output busy_res, output done_res,
		output status, output temp_tenths, input ready);
	modport sink (input valid, input dq_pull_low, input busy_res, input done_res,
		input status, input temp_tenths, output ready);
endinterface

### rtl/core/owc_cfg_if.sv
interface owc_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [9:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/owc_cfg_regs.sv
module owc_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	owc_cfg_if.sink         cfg,
	output owc_pkg::owc_cfg_t regs
);
	import owc_pkg::*;

	owc_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	// register writes, spec timing after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.reset_low   <= 10'd480;
			regs_q.pres_window <= 10'd70;
			regs_q.reset_tail  <= 10'd410;
			regs_q.slot_low    <= 4'd2;
			regs_q.read_sample <= 4'd12;
			regs_q.slot        <= 10'd70;
			regs_q.recovery    <= 8'd2;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_RESET_LOW:   regs_q.reset_low   <= cfg.data;
				REG_PRES_WINDOW: regs_q.pres_window <= cfg.data;
				REG_RESET_TAIL:  regs_q.reset_tail  <= cfg.data;
				REG_SLOT_LOW:    regs_q.slot_low    <= cfg.data[3:0];
				REG_READ_SAMPLE: regs_q.read_sample <= cfg.data[3:0];
				REG_SLOT:        regs_q.slot        <= cfg.data;
				REG_RECOVERY:    regs_q.recovery    <= cfg.data[7:0];
				default: ;
			endcase
		end
	end
endmodule

### rtl/core/owc_conv.sv
module owc_conv (
	input  logic [15:0]        raw,
	output logic [1:0]         status,
	output logic signed [15:0] temp
);
	import owc_pkg::*;

	logic signed [19:0] r20;
	logic signed [19:0] t20;
	logic [19:0]        mag;
	logic [19:0]        rnd;
	logic [15:0]        q;

	// raw * 10 / 16, rounded half away from zero; all ones gives the invalid status and temperature
	always_comb begin
		r20 = {{4{raw[15]}}, raw};
		t20 = (r20 <<< 3) + (r20 <<< 1);
		mag = t20[19] ? 20'(-t20) : 20'(t20);
		rnd = mag + 20'd8;
		q = rnd[19:4];
		if (raw == RAW_ALL_ONES) begin
			status = ST_ALL_ONES;
			temp = TEMP_INVALID;
		end else begin
			status = ST_OK;
			temp = t20[19] ? 16'(-q) : q;
		end
	end
endmodule

### rtl/core/owc_seq.sv
module owc_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [1:0]        req_type,
	input  logic              dq_level,
	input  owc_pkg::owc_cfg_t regs,
	output owc_pkg::owc_res_t res
);
	import owc_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_PRES,
		PH_TAIL,
		PH_SLOT,
		PH_RECOV
	} phase_t;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	phase_t             phase_q, ph, ph_d;
	logic [CNT_W-1:0]   tc_q, tc, tc_d;
	logic [2:0]         bit_q, bt, bit_d, bit_nx;
	logic [1:0]         byte_q, byt, byte_d;
	logic [7:0]         shift_q, shf, shf_d;
	logic [7:0]         low_q, low_d;
	logic               pres_q, pres, pres_d;
	logic               rd_q, rd, rd_d;
	logic signed [15:0] temp_q, temp_d;
	logic [1:0]         status_q, status_d;
	logic               start, reading, fin;
	logic               pull, busy, done;
	logic [1:0]         conv_status;
	logic signed [15:0] conv_temp;

	// last tick of a span of len ticks
	function automatic logic span_end(input logic [CNT_W-1:0] c, input logic [CFG_W-1:0] len);
		logic [CMP_W-1:0] c1;
		begin
			c1 = CMP_W'(c) + CMP_W'(1);
			return (c1 >= CMP_W'(len)) || (c == CNT_MAX);
		end
	endfunction

	owc_conv u_conv (
		.raw    ({shf, low_q}),
		.status (conv_status),
		.temp   (conv_temp)
	);

	// next state for one tick
	always_comb begin
		start = (phase_q == PH_IDLE) && (req_type == REQ_CONVERT || req_type == REQ_READ);
		ph   = start ? PH_RST_LOW : phase_q;
		tc   = start ? '0 : tc_q;
		bt   = start ? '0 : bit_q;
		byt  = start ? '0 : byte_q;
		shf  = start ? '0 : shift_q;
		pres = start ? 1'b0 : pres_q;
		rd   = start ? (req_type == REQ_READ) : rd_q;

		ph_d = ph;
		tc_d = tc;
		bit_d = bt;
		byte_d = byt;
		shf_d = shf;
		pres_d = pres;
		rd_d = rd;
		low_d = low_q;
		temp_d = temp_q;
		status_d = status_q;
		pull = 1'b0;
		busy = 1'b0;
		done = 1'b0;
		fin = 1'b0;
		reading = byt[1];
		bit_nx = bt + 3'd1;

		if (ph != PH_IDLE) begin
			busy = 1'b1;
			case (ph)
				PH_RST_LOW: begin
					pull = 1'b1;
					if (span_end(tc, regs.reset_low)) begin
						ph_d = PH_PRES;
						tc_d = '0;
					end else begin
						tc_d = tc + CNT_W'(1);
					end
				end
				PH_PRES: begin
					if (!dq_level) pres_d = 1'b1;
					if (span_end(tc, regs.pres_window)) begin
						ph_d = PH_TAIL;
						tc_d = '0;
					end else begin
						tc_d = tc + CNT_W'(1);
					end
				end
				PH_TAIL: begin
					if (!span_end(tc, regs.reset_tail)) begin
						tc_d = tc + CNT_W'(1);
					end else if (pres) begin
						shf_d = ROM_SKIP;
						byte_d = '0;
						bit_d = '0;
						ph_d = PH_SLOT;
						tc_d = '0;
					end else begin
						if (rd) begin
							status_d = ST_NO_PRES;
							temp_d = TEMP_INVALID;
						end
						fin = 1'b1;
					end
				end
				PH_SLOT: begin
					if (CMP_W'(tc) < CMP_W'(regs.slot_low)) pull = 1'b1;
					else if (!reading && !shf[0]) pull = 1'b1;
					if (reading && CMP_W'(tc) == CMP_W'(regs.read_sample))
						shf_d = shf | (8'(dq_level) << bt);
					if (span_end(tc, regs.slot)) begin
						ph_d = PH_RECOV;
						tc_d = '0;
					end else begin
						tc_d = tc + CNT_W'(1);
					end
				end
				PH_RECOV: begin
					if (!span_end(tc, CFG_W'(regs.recovery))) begin
						tc_d = tc + CNT_W'(1);
					end else begin
						if (!reading) shf_d = shf >> 1;
						bit_d = bit_nx;
						tc_d = '0;
						if (bit_nx != 3'd0) begin
							ph_d = PH_SLOT;
						end else begin
							case (byt)
								2'd0: begin
									shf_d = rd ? FN_READ_PAD : FN_CONVERT;
									byte_d = 2'd1;
									ph_d = PH_SLOT;
								end
								2'd1: begin
									if (!rd) begin
										fin = 1'b1;
									end else begin
										shf_d = '0;
										byte_d = 2'd2;
										ph_d = PH_SLOT;
									end
								end
								2'd2: begin
									low_d = shf;
									shf_d = '0;
									byte_d = 2'd3;
									ph_d = PH_SLOT;
								end
								default: begin
									status_d = conv_status;
									temp_d = conv_temp;
									fin = 1'b1;
								end
							endcase
						end
					end
				end
				default: ;
			endcase
			if (fin) begin
				ph_d = PH_IDLE;
				tc_d = '0;
				busy = 1'b0;
				done = 1'b1;
			end
		end

		res.pull = pull;
		res.busy = busy;
		res.done = done;
		res.status = status_d;
		res.temp = temp_d;
	end

	// sequencer state, advanced once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tc_q <= '0;
			bit_q <= '0;
			byte_q <= '0;
			shift_q <= '0;
			low_q <= '0;
			pres_q <= 1'b0;
			rd_q <= 1'b0;
			temp_q <= TEMP_INVALID;
			status_q <= ST_NO_PRES;
		end else if (step) begin
			phase_q <= ph_d;
			tc_q <= tc_d;
			bit_q <= bit_d;
			byte_q <= byte_d;
			shift_q <= shf_d;
			low_q <= low_d;
			pres_q <= pres_d;
			rd_q <= rd_d;
			temp_q <= temp_d;
			status_q <= status_d;
		end
	end

	// a completed sequence lands in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done |=> phase_q == PH_IDLE)
		else $error("done without return to idle");

	// idle keeps the counters cleared
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> tc_q == '0 && bit_q == '0)
		else $error("counters not cleared in idle");

	// read bytes only happen for a read command
	a_read_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		byte_q[1] |-> rd_q)
		else $error("read byte phase on convert command");

	// bus is never driven outside a sequence
	a_pull_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.pull |-> res.busy)
		else $error("bus pulled low while not busy");
endmodule

### rtl/core/onewire_temp_sensor_reader.sv
// channel | dir | handshake      | payload
// cmd     | in  | valid/ready    | req_type, dq_level
// res     | out | valid/ready    | dq_pull_low, busy_res, done_res, status, temp_tenths
// cfg     | in  | valid/ready    | index, data (timing registers 0..6)
//
// each cmd beat is one bus tick and yields one registered res beat in the following cycle
// one beat per cycle sustained while res.ready is high; the sequencer step is a single register stage
// cmd.ready is low only while a result is held and res.ready is low
// reset loads spec timing, idle phase, status no-presence and the invalid temperature
// cfg.ready is always high; writes take effect on the next cmd beat
module onewire_temp_sensor_reader (
	input  logic     clk,
	input  logic     arst_n,
	owc_cmd_if.sink  cmd,
	owc_res_if.source res,
	owc_cfg_if.sink  cfg
);
	import owc_pkg::*;

	owc_cfg_t regs;
	owc_res_t step_res;
	owc_res_t res_q;
	logic     res_valid_q;
	logic     step;

	// accept while the result register is free or draining
	assign cmd.ready = !res_valid_q || res.ready;
	assign step = cmd.valid && cmd.ready;

	owc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	owc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.req_type (cmd.req_type),
		.dq_level (cmd.dq_level),
		.regs     (regs),
		.res      (step_res)
	);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= step_res;
		end
	end

	assign res.valid = res_valid_q;
	assign res.dq_pull_low = res_q.pull;
	assign res.busy_res = res_q.busy;
	assign res.done_res = res_q.done;
	assign res.status = res_q.status;
	assign res.temp_tenths = res_q.temp;
endmodule
